// ===== rtl/pc_hist_pkg.sv =====
// shared constants, state type and saturating increment helper for the pc sample histogram
package pc_hist_pkg;

  localparam int unsigned ENTRIES = 4096;
  localparam int unsigned ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned USED_W  = $clog2(ENTRIES + 1);
  localparam int unsigned IP_W    = 64;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned UNIQ_W  = 13;

  localparam logic [IP_W-1:0]  KERNEL_BASE_RESET = 64'h0000_0000_c000_0000;
  localparam logic [CNT_W-1:0] COUNT_MAX         = '1;

  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_READ   = 4'b0100,
    S_OUT    = 4'b1000
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ===== rtl/pc_sample_histogram_unit.sv =====
// pc sample histogram: kernel filter, sequential table search, append and slot read
// record transaction: kernel address skips the table and goes to the result; empty
//   table appends with no compare; user address, one slot compared per cycle on the single
//   memory read port: a hit updates its count, a miss appends, or drops if full
// read transaction: slot read, then result; next accept in the cycle after the result
//   loads, so a stalled result holds one more transaction waiting; reset clears control
module pc_sample_histogram_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pc_hist_pkg::IP_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [pc_hist_pkg::IP_W-1:0]  in_sample_ip,
  input  logic [pc_hist_pkg::IDX_W-1:0] in_read_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pc_hist_pkg::IP_W-1:0]  out_entry_ip,
  output logic [pc_hist_pkg::CNT_W-1:0] out_entry_count,
  output logic [pc_hist_pkg::IDX_W-1:0] out_slot_index,
  output logic                          out_is_kernel,
  output logic                          out_dropped,
  output logic                          out_entry_valid,
  output logic [pc_hist_pkg::CNT_W-1:0] out_total_samples,
  output logic [pc_hist_pkg::CNT_W-1:0] out_kernel_samples,
  output logic [pc_hist_pkg::UNIQ_W-1:0] out_unique_entries
);

  pc_hist_pkg::state_t state_r, state_nxt;

  logic [pc_hist_pkg::IP_W-1:0]   kbase_r, kbase_nxt;
  logic [pc_hist_pkg::IP_W-1:0]   ip_r, ip_nxt;
  logic [pc_hist_pkg::USED_W-1:0] scan_r, scan_nxt;
  logic                           cmp_vld_r, cmp_vld_nxt;
  logic [pc_hist_pkg::ADDR_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [pc_hist_pkg::USED_W-1:0] used_r, used_nxt;
  logic [pc_hist_pkg::CNT_W-1:0]  total_r, total_nxt;
  logic [pc_hist_pkg::CNT_W-1:0]  kern_r, kern_nxt;
  logic [pc_hist_pkg::IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic                           rd_ok_r, rd_ok_nxt;

  logic [pc_hist_pkg::IP_W-1:0]   res_ip_r, res_ip_nxt;
  logic [pc_hist_pkg::CNT_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic [pc_hist_pkg::IDX_W-1:0]  res_slot_r, res_slot_nxt;
  logic                           res_kern_r, res_kern_nxt;
  logic                           res_drop_r, res_drop_nxt;
  logic                           res_valid_r, res_valid_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [pc_hist_pkg::IP_W-1:0]   out_ip_r, out_ip_nxt;
  logic [pc_hist_pkg::CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [pc_hist_pkg::IDX_W-1:0]  out_slot_r, out_slot_nxt;
  logic                           out_kern_r, out_kern_nxt;
  logic                           out_drop_r, out_drop_nxt;
  logic                           out_ev_r, out_ev_nxt;
  logic [pc_hist_pkg::CNT_W-1:0]  out_total_r, out_total_nxt;
  logic [pc_hist_pkg::CNT_W-1:0]  out_ksamp_r, out_ksamp_nxt;
  logic [pc_hist_pkg::UNIQ_W-1:0] out_uniq_r, out_uniq_nxt;

  // slot table
  logic [pc_hist_pkg::IP_W-1:0]   slot_address_mem [pc_hist_pkg::ENTRIES];
  logic [pc_hist_pkg::CNT_W-1:0]  slot_count_mem [pc_hist_pkg::ENTRIES];
  logic [pc_hist_pkg::ADDR_W-1:0] rd_addr;
  logic [pc_hist_pkg::IP_W-1:0]   rd_ip_r;
  logic [pc_hist_pkg::CNT_W-1:0]  rd_cnt_r;
  logic                           wr_en;
  logic [pc_hist_pkg::ADDR_W-1:0] wr_addr;
  logic [pc_hist_pkg::IP_W-1:0]   wr_ip;
  logic [pc_hist_pkg::CNT_W-1:0]  wr_cnt;

  logic in_accept;
  logic hit_cnt_sat;

  assign in_stall  = (state_r != pc_hist_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign hit_cnt_sat = 1'b0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_address_mem[wr_addr] <= wr_ip;
      slot_count_mem[wr_addr]   <= wr_cnt;
    end
    rd_ip_r  <= slot_address_mem[rd_addr];
    rd_cnt_r <= slot_count_mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    kbase_nxt     = cfg_we ? cfg_wdata : kbase_r;
    ip_nxt        = ip_r;
    scan_nxt      = scan_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    used_nxt      = used_r;
    total_nxt     = total_r;
    kern_nxt      = kern_r;
    rd_idx_nxt    = rd_idx_r;
    rd_ok_nxt     = rd_ok_r;
    res_ip_nxt    = res_ip_r;
    res_cnt_nxt   = res_cnt_r;
    res_slot_nxt  = res_slot_r;
    res_kern_nxt  = res_kern_r;
    res_drop_nxt  = res_drop_r;
    res_valid_nxt = res_valid_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ip_nxt    = out_ip_r;
    out_cnt_nxt   = out_cnt_r;
    out_slot_nxt  = out_slot_r;
    out_kern_nxt  = out_kern_r;
    out_drop_nxt  = out_drop_r;
    out_ev_nxt    = out_ev_r;
    out_total_nxt = out_total_r;
    out_ksamp_nxt = out_ksamp_r;
    out_uniq_nxt  = out_uniq_r;
    rd_addr       = scan_r[pc_hist_pkg::ADDR_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = used_r[pc_hist_pkg::ADDR_W-1:0];
    wr_ip         = ip_r;
    wr_cnt        = pc_hist_pkg::CNT_W'(1);

    case (state_r)
      pc_hist_pkg::S_IDLE: begin
        if (in_accept) begin
          res_ip_nxt    = '0;
          res_cnt_nxt   = '0;
          res_slot_nxt  = '0;
          res_kern_nxt  = 1'b0;
          res_drop_nxt  = 1'b0;
          res_valid_nxt = 1'b0;
          if (in_action == pc_hist_pkg::ACT_READ) begin
            rd_addr    = pc_hist_pkg::ADDR_W'(in_read_index);
            rd_idx_nxt = in_read_index;
            rd_ok_nxt  = (32'(in_read_index) < 32'(used_r)) &&
                         (32'(in_read_index) < 32'(pc_hist_pkg::ENTRIES));
            state_nxt  = pc_hist_pkg::S_READ;
          end else begin
            total_nxt = pc_hist_pkg::sat_inc(total_r);
            ip_nxt    = in_sample_ip;
            if (in_sample_ip >= kbase_r) begin
              kern_nxt     = pc_hist_pkg::sat_inc(kern_r);
              res_kern_nxt = 1'b1;
              state_nxt    = pc_hist_pkg::S_OUT;
            end else begin
              scan_nxt  = '0;
              state_nxt = pc_hist_pkg::S_SEARCH;
            end
          end
        end
      end
      pc_hist_pkg::S_SEARCH: begin
        // issue one slot read per cycle, compare the previous slot's data
        if (cmp_vld_r && (rd_ip_r == ip_r)) begin
          wr_en         = 1'b1;
          wr_addr       = cmp_idx_r;
          wr_cnt        = pc_hist_pkg::sat_inc(rd_cnt_r);
          res_ip_nxt    = ip_r;
          res_cnt_nxt   = pc_hist_pkg::sat_inc(rd_cnt_r);
          res_slot_nxt  = pc_hist_pkg::IDX_W'(cmp_idx_r);
          res_valid_nxt = 1'b1;
          state_nxt     = pc_hist_pkg::S_OUT;
        end else if (scan_r < used_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_r[pc_hist_pkg::ADDR_W-1:0];
          scan_nxt    = scan_r + 1'b1;
        end else if (!cmp_vld_r) begin
          if (32'(used_r) < 32'(pc_hist_pkg::ENTRIES)) begin
            wr_en         = 1'b1;
            used_nxt      = used_r + 1'b1;
            res_ip_nxt    = ip_r;
            res_cnt_nxt   = pc_hist_pkg::CNT_W'(1);
            res_slot_nxt  = pc_hist_pkg::IDX_W'(used_r);
            res_valid_nxt = 1'b1;
          end else begin
            res_drop_nxt = 1'b1;
          end
          state_nxt = pc_hist_pkg::S_OUT;
        end
      end
      pc_hist_pkg::S_READ: begin
        res_slot_nxt  = rd_idx_r;
        res_valid_nxt = rd_ok_r;
        res_ip_nxt    = rd_ok_r ? rd_ip_r : '0;
        res_cnt_nxt   = rd_ok_r ? rd_cnt_r : '0;
        state_nxt     = pc_hist_pkg::S_OUT;
      end
      pc_hist_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ip_nxt    = res_ip_r;
          out_cnt_nxt   = res_cnt_r;
          out_slot_nxt  = res_slot_r;
          out_kern_nxt  = res_kern_r;
          out_drop_nxt  = res_drop_r;
          out_ev_nxt    = res_valid_r;
          out_total_nxt = total_r;
          out_ksamp_nxt = kern_r;
          out_uniq_nxt  = pc_hist_pkg::UNIQ_W'(used_r);
          state_nxt     = pc_hist_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pc_hist_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pc_hist_pkg::S_IDLE;
      kbase_r     <= pc_hist_pkg::KERNEL_BASE_RESET;
      cmp_vld_r   <= 1'b0;
      used_r      <= '0;
      total_r     <= '0;
      kern_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kbase_r     <= kbase_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      used_r      <= used_nxt;
      total_r     <= total_nxt;
      kern_r      <= kern_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ip_r        <= ip_nxt;
    scan_r      <= scan_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    rd_idx_r    <= rd_idx_nxt;
    rd_ok_r     <= rd_ok_nxt;
    res_ip_r    <= res_ip_nxt;
    res_cnt_r   <= res_cnt_nxt;
    res_slot_r  <= res_slot_nxt;
    res_kern_r  <= res_kern_nxt;
    res_drop_r  <= res_drop_nxt;
    res_valid_r <= res_valid_nxt;
    out_ip_r    <= out_ip_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_slot_r  <= out_slot_nxt;
    out_kern_r  <= out_kern_nxt;
    out_drop_r  <= out_drop_nxt;
    out_ev_r    <= out_ev_nxt;
    out_total_r <= out_total_nxt;
    out_ksamp_r <= out_ksamp_nxt;
    out_uniq_r  <= out_uniq_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_entry_ip       = out_ip_r;
  assign out_entry_count    = out_cnt_r | {pc_hist_pkg::CNT_W{hit_cnt_sat}};
  assign out_slot_index     = out_slot_r;
  assign out_is_kernel      = out_kern_r;
  assign out_dropped        = out_drop_r;
  assign out_entry_valid    = out_ev_r;
  assign out_total_samples  = out_total_r;
  assign out_kernel_samples = out_ksamp_r;
  assign out_unique_entries = out_uniq_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= 32'(pc_hist_pkg::ENTRIES))
    else $error("used slot count above table size");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pc_hist_pkg::S_SEARCH) |-> (scan_r <= used_r))
    else $error("search pointer past used slots");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_drop_r) |->
      (!out_ev_r && (32'(used_r) == 32'(pc_hist_pkg::ENTRIES))))
    else $error("drop flagged while table has room");

  a_kernel_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kern_r) |-> (!out_ev_r && !out_drop_r))
    else $error("kernel sample reported a table slot");

endmodule
